/* hw/rtl/sorted_record_table_assert.svh */
// Assertion macros for the sorted record table.
// Included by RTL modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_RECORD_TABLE_ASSERT_SVH
`define SORTED_RECORD_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SRT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SRT_ASSERT(label, clk, rst_n, prop, msg)
`define SRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/srt_pkg.sv */
// Shared types and codes for the sorted record table.
// No dependencies; used by every module of the block.
`default_nettype none
package srt_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] line_key;
        logic [7:0]  stop_count;
        logic [15:0] ride_duration;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  found_index;
        logic [6:0]  entry_count;
        logic [13:0] total_stops;
        logic [21:0] total_duration;
        logic [15:0] shortest_key;
        logic        shortest_valid;
    } t_result;
endpackage
`default_nettype wire

/* hw/rtl/sorted_record_table.sv */
// Sorted record table: the top level, with the record memory and its sequencer.
// Depends on srt_pkg and sorted_record_table_assert.svh.
//
// A request is taken when i_start is high and o_busy is low. Exactly one result
// follows on o_result, marked by o_done for one cycle, and the receiver cannot
// stall it. o_busy stays high during the o_done cycle. All work runs through one
// memory port and one shared compare/add unit, so the steps run one after another:
// - a binary search reads and compares at each probe, then reads the settled bound;
// - an insert or delete moves one record per read/write pair over the records
//   behind the position;
// - a final sweep reads every record to find the shortest
//   duration.
// A new request is therefore taken only after the previous result.
`default_nettype none
module sorted_record_table #(
    parameter int DEPTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire srt_pkg::t_request i_request,
    output logic                  o_busy,
    output logic                  o_done,
    output srt_pkg::t_result      o_result
);
    `include "sorted_record_table_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SRCH, S_SRCH_RD, S_HIT, S_SHIFT_RD, S_SHIFT_WR,
        S_PUT, S_MIN_RD, S_MIN, S_DONE
    } t_state;

    // Record memory: one port, registered read.
    logic [39:0] mem [DEPTH];
    logic [39:0] r_rd;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [39:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    t_state r_state;
    srt_pkg::t_request r_req;
    logic [CW-1:0] r_count, r_lo, r_hi, r_ptr;
    logic [13:0]   r_stops;
    logic [22:0]   r_dur;
    logic [2:0]    r_status;
    logic [AW-1:0] r_index;
    logic [15:0]   r_best_key, r_best_dur;
    logic          r_done;

    logic [CW-1:0] mid;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    logic [CW-1:0] ptr_dn;
    assign ptr_dn = r_ptr - 1'b1;

    logic is_insert;
    assign is_insert = (r_req.opcode == srt_pkg::OP_INSERT);

    // Memory port steering. An insert shift reads one place below the pointer and
    // writes at it; a delete shift reads at the pointer and writes one place below.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ptr[AW-1:0];
        mem_wd = r_rd;
        mem_ra = r_ptr[AW-1:0];
        unique case (r_state)
            S_SRCH:     mem_ra = mid[AW-1:0];
            S_SHIFT_RD: mem_ra = is_insert ? ptr_dn[AW-1:0] : r_ptr[AW-1:0];
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_wa = is_insert ? r_ptr[AW-1:0] : ptr_dn[AW-1:0];
            end
            S_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_lo[AW-1:0];
                mem_wd = {r_req.line_key, r_req.stop_count, r_req.ride_duration};
            end
            default: ;
        endcase
    end

    // Sequencer with the shared compare unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_stops <= '0;
            r_dur   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && !o_busy) begin
                        r_req    <= i_request;
                        r_status <= srt_pkg::ST_OK;
                        r_index  <= '0;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_req.opcode == srt_pkg::OP_INSERT) begin
                        if (r_req.line_key == '0 || r_req.stop_count == '0 ||
                            r_req.ride_duration == '0) begin
                            r_status <= srt_pkg::ST_INVALID;
                            r_ptr <= '0; r_state <= S_MIN_RD;
                        end else if (r_count >= CW'(DEPTH)) begin
                            r_status <= srt_pkg::ST_FULL;
                            r_ptr <= '0; r_state <= S_MIN_RD;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end else if (r_req.opcode == srt_pkg::OP_DELETE ||
                                 r_req.opcode == srt_pkg::OP_LOOKUP) begin
                        r_state <= S_SRCH;
                    end else begin
                        r_status <= srt_pkg::ST_INVALID;
                        r_ptr <= '0; r_state <= S_MIN_RD;
                    end
                end
                // Probe the midpoint, or read the lower bound once it settles.
                S_SRCH: begin
                    r_ptr <= mid;
                    if (r_lo < r_hi) begin
                        r_state <= S_SRCH_RD;
                    end else begin
                        r_state <= S_HIT;
                    end
                end
                S_SRCH_RD: begin
                    if (r_rd[39:24] < r_req.line_key) begin
                        r_lo <= r_ptr + 1'b1;
                    end else begin
                        r_hi <= r_ptr;
                    end
                    r_state <= S_SRCH;
                end
                S_HIT: begin
                    if ((r_lo < r_count) && (r_rd[39:24] == r_req.line_key)) begin
                        if (r_req.opcode == srt_pkg::OP_INSERT) begin
                            r_status <= srt_pkg::ST_DUP;
                            r_ptr <= '0; r_state <= S_MIN_RD;
                        end else if (r_req.opcode == srt_pkg::OP_LOOKUP) begin
                            r_index <= r_lo[AW-1:0];
                            r_ptr <= '0; r_state <= S_MIN_RD;
                        end else begin
                            r_stops <= r_stops - 14'(r_rd[23:16]);
                            r_dur   <= r_dur - 23'(r_rd[15:0]);
                            r_ptr   <= r_lo + 1'b1;
                            r_state <= S_SHIFT_RD;
                        end
                    end else if (r_req.opcode == srt_pkg::OP_INSERT) begin
                        r_index <= r_lo[AW-1:0];
                        r_ptr   <= r_count;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_status <= srt_pkg::ST_NOTFOUND;
                        r_ptr <= '0; r_state <= S_MIN_RD;
                    end
                end
                // Move one record per read/write pair.
                S_SHIFT_RD: begin
                    if (r_req.opcode == srt_pkg::OP_INSERT) begin
                        if (r_ptr > r_lo) begin
                            r_state <= S_SHIFT_WR;
                        end else begin
                            r_state <= S_PUT;
                        end
                    end else if (r_ptr < r_count) begin
                        r_state <= S_SHIFT_WR;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_ptr <= '0; r_state <= S_MIN_RD;
                    end
                end
                S_SHIFT_WR: begin
                    if (r_req.opcode == srt_pkg::OP_INSERT) begin
                        r_ptr <= ptr_dn;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                        r_state <= S_SHIFT_RD;
                    end
                end
                S_PUT: begin
                    r_count <= r_count + 1'b1;
                    r_stops <= r_stops + 14'(r_req.stop_count);
                    r_dur   <= r_dur + 23'(r_req.ride_duration);
                    r_ptr <= '0; r_state <= S_MIN_RD;
                end
                // Minimum sweep: one record per read/compare pair.
                S_MIN_RD: begin
                    r_state <= (r_ptr < r_count) ? S_MIN : S_DONE;
                end
                S_MIN: begin
                    if (r_ptr == '0 || r_rd[15:0] < r_best_dur) begin
                        r_best_dur <= r_rd[15:0];
                        r_best_key <= r_rd[39:24];
                    end
                    r_ptr <= r_ptr + 1'b1;
                    r_state <= S_MIN_RD;
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE) || r_done;
    assign o_done = r_done;
    always_comb begin
        o_result.status         = r_status;
        o_result.found_index    = 6'(r_index);
        o_result.entry_count    = 7'(r_count);
        o_result.total_stops    = r_stops;
        o_result.total_duration = r_dur[21:0];
        o_result.shortest_key   = (r_count != '0) ? r_best_key : 16'd0;
        o_result.shortest_valid = (r_count != '0);
    end

    `SRT_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count overflow")
    `SRT_ASSERT(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "done not a pulse")
    `SRT_ASSERT(a_busy_no_start, i_clk, i_rst_n,
        (i_start && !o_busy) |=> (r_state == S_CHECK), "request not taken")
endmodule
`default_nettype wire
